@@ rtl/assert_macros.svh @@
// Assertion macros shared by the line position and drive RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPPD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lppd_pkg.sv @@
// Shared constants, types and tables of the line position and drive block.
package lppd_pkg;

   localparam int NUM_SENSORS   = 8;
   localparam int SAMPLE_BITS   = 12;
   localparam int HISTORY_DEPTH = 6;
   localparam int MAX_DUTY      = 100;

   localparam int PITCH         = 100;
   localparam int POS_MAX       = PITCH * (NUM_SENSORS - 1);
   localparam int EDGE_MARGIN   = 50;

   localparam int MODE_W        = 2;
   localparam int POS_W         = 10;
   localparam int TARGET_W      = POS_W;
   localparam int GAIN_W        = 8;
   localparam int BASE_W        = 8;
   localparam int DUTY_W        = 7;
   localparam int ERR_W         = POS_W + 1;
   localparam int DIFF_W        = ERR_W + 1;

   localparam int COUNT_W       = $clog2(NUM_SENSORS + 1);
   localparam int WSUM_W        = $clog2(PITCH * NUM_SENSORS * (NUM_SENSORS - 1) / 2 + 1);

   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(350);
   localparam logic [BASE_W-1:0]   BASE_RESET   = BASE_W'(20);

   // Rounded-up reciprocals of the hit count, scaled by two to the RECIP_SHIFT.
   // The scale keeps the overshoot below one count step for every centroid.
   localparam int RECIP_SHIFT = 17;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP_TABLE [NUM_SENSORS + 1] = '{
      RECIP_W'(0),
      RECIP_W'(131072),
      RECIP_W'(65536),
      RECIP_W'(43691),
      RECIP_W'(32768),
      RECIP_W'(26215),
      RECIP_W'(21846),
      RECIP_W'(18725),
      RECIP_W'(16384)
   };

   typedef enum logic [MODE_W-1:0] {
      MODE_LINE       = 2'd0,
      MODE_BACKGROUND = 2'd1,
      MODE_RUN        = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REG_TARGET = 3'd0,
      REG_GAIN_P = 3'd1,
      REG_GAIN_D = 3'd2,
      REG_GAIN_I = 3'd3,
      REG_BASE   = 3'd4,
      REG_DRIVE  = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_POS,
      ST_P,
      ST_D,
      ST_I,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic cap_ref;
      logic cap_thr;
      logic cmp;
   } lane_ctrl_type;

   typedef struct packed {
      logic sum_load;
      logic div_load;
      logic pos_load;
      logic p_load;
      logic d_load;
      logic i_load;
   } ctrl_type;

   typedef struct packed {
      logic [DUTY_W-1:0] left_duty;
      logic              left_reverse;
      logic [DUTY_W-1:0] right_duty;
      logic              right_reverse;
   } drive_type;

endpackage

@@ rtl/line_position_pid_drive_core.sv @@
// Top level of the line position and PID drive block.
// Each accepted word carries eight sensor samples and a mode; every word gives
// exactly one result word. Capture words (modes 0, 1 and the unused mode 3) go
// from acceptance straight to the result state; a run word first passes SUM, DIV
// and POS, and with drive enabled also P, D and I. The sequencer sets the order:
// eight parallel lanes compare in the cycle of acceptance, the merging stage then
// works through count and weighted sum, the reciprocal multiply and the corrected
// centroid, and the PID step follows, its proportional, derivative and integral
// products going in turn through one shared multiplier. A finished result waits
// in an output register, and the block accepts its next word as soon as that
// register has been loaded, which waits while an unread result still sits there.
// There is no clearing pass after reset. Registers sit at byte addresses 4*i:
// target position, P, D and I gains, base speed and drive enable.
`include "assert_macros.svh"

module line_position_pid_drive_core #(
   parameter int SAMPLE_BITS   = lppd_pkg::SAMPLE_BITS,
   parameter int HISTORY_DEPTH = lppd_pkg::HISTORY_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lppd_pkg::MODE_W-1:0]       req_mode,
   input  logic [SAMPLE_BITS-1:0]            req_sample_0,
   input  logic [SAMPLE_BITS-1:0]            req_sample_1,
   input  logic [SAMPLE_BITS-1:0]            req_sample_2,
   input  logic [SAMPLE_BITS-1:0]            req_sample_3,
   input  logic [SAMPLE_BITS-1:0]            req_sample_4,
   input  logic [SAMPLE_BITS-1:0]            req_sample_5,
   input  logic [SAMPLE_BITS-1:0]            req_sample_6,
   input  logic [SAMPLE_BITS-1:0]            req_sample_7,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lppd_pkg::POS_W-1:0]        rsp_position,
   output logic                              rsp_line_seen,
   output logic [lppd_pkg::NUM_SENSORS-1:0]  rsp_sensor_bits,
   output logic [lppd_pkg::DUTY_W-1:0]       rsp_left_duty,
   output logic                              rsp_left_reverse,
   output logic [lppd_pkg::DUTY_W-1:0]       rsp_right_duty,
   output logic                              rsp_right_reverse,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lppd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lppd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lppd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int NS = lppd_pkg::NUM_SENSORS;

   // Configuration registers.
   logic [lppd_pkg::TARGET_W-1:0]      target_ff, target_in;
   logic [lppd_pkg::GAIN_W-1:0]        gain_p_ff, gain_p_in;
   logic [lppd_pkg::GAIN_W-1:0]        gain_d_ff, gain_d_in;
   logic [lppd_pkg::GAIN_W-1:0]        gain_i_ff, gain_i_in;
   logic signed [lppd_pkg::BASE_W-1:0] base_ff, base_in;
   logic                               drive_en_ff, drive_en_in;
   logic                               csr_write;
   lppd_pkg::reg_index_type            csr_index;

   // Sequencer and result register.
   lppd_pkg::state_type                state_ff, state_in;
   logic [lppd_pkg::MODE_W-1:0]        mode_ff, mode_in;
   lppd_pkg::lane_ctrl_type            lane_ctrl;
   lppd_pkg::ctrl_type                 ctrl;
   logic                               rsp_load;
   logic                               run_item;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lppd_pkg::POS_W-1:0]         rsp_position_ff;
   logic                               rsp_line_seen_ff;
   logic [NS-1:0]                      rsp_bits_ff;
   lppd_pkg::drive_type                rsp_drive_ff, rsp_drive_in;

   logic [SAMPLE_BITS-1:0]             sample_vec [NS];
   logic [NS-1:0]                      hits;
   logic [lppd_pkg::POS_W-1:0]         position;
   lppd_pkg::drive_type                drive;

   assign sample_vec[0] = req_sample_0;
   assign sample_vec[1] = req_sample_1;
   assign sample_vec[2] = req_sample_2;
   assign sample_vec[3] = req_sample_3;
   assign sample_vec[4] = req_sample_4;
   assign sample_vec[5] = req_sample_5;
   assign sample_vec[6] = req_sample_6;
   assign sample_vec[7] = req_sample_7;

   // ---------------- configuration port ----------------
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = lppd_pkg::reg_index_type'(csr_paddr[lppd_pkg::CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      target_in   = target_ff;
      gain_p_in   = gain_p_ff;
      gain_d_in   = gain_d_ff;
      gain_i_in   = gain_i_ff;
      base_in     = base_ff;
      drive_en_in = drive_en_ff;
      if (csr_write) begin
         unique case (csr_index)
            lppd_pkg::REG_TARGET: target_in   = csr_pwdata[lppd_pkg::TARGET_W-1:0];
            lppd_pkg::REG_GAIN_P: gain_p_in   = csr_pwdata[lppd_pkg::GAIN_W-1:0];
            lppd_pkg::REG_GAIN_D: gain_d_in   = csr_pwdata[lppd_pkg::GAIN_W-1:0];
            lppd_pkg::REG_GAIN_I: gain_i_in   = csr_pwdata[lppd_pkg::GAIN_W-1:0];
            lppd_pkg::REG_BASE:   base_in     = csr_pwdata[lppd_pkg::BASE_W-1:0];
            lppd_pkg::REG_DRIVE:  drive_en_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         lppd_pkg::REG_TARGET: csr_prdata = lppd_pkg::CSR_DATA_W'(target_ff);
         lppd_pkg::REG_GAIN_P: csr_prdata = lppd_pkg::CSR_DATA_W'(gain_p_ff);
         lppd_pkg::REG_GAIN_D: csr_prdata = lppd_pkg::CSR_DATA_W'(gain_d_ff);
         lppd_pkg::REG_GAIN_I: csr_prdata = lppd_pkg::CSR_DATA_W'(gain_i_ff);
         lppd_pkg::REG_BASE:   csr_prdata = lppd_pkg::CSR_DATA_W'($unsigned(base_ff));
         lppd_pkg::REG_DRIVE:  csr_prdata = lppd_pkg::CSR_DATA_W'(drive_en_ff);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= lppd_pkg::TARGET_RESET;
         gain_p_ff   <= '0;
         gain_d_ff   <= '0;
         gain_i_ff   <= '0;
         base_ff     <= lppd_pkg::BASE_RESET;
         drive_en_ff <= 1'b0;
      end else begin
         target_ff   <= target_in;
         gain_p_ff   <= gain_p_in;
         gain_d_ff   <= gain_d_in;
         gain_i_ff   <= gain_i_in;
         base_ff     <= base_in;
         drive_en_ff <= drive_en_in;
      end
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lppd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      lane_ctrl = '0;
      ctrl      = '0;
      rsp_load  = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         lppd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // The lanes capture or compare at the edge that takes the word.
               mode_in           = req_mode;
               lane_ctrl.cap_ref = (req_mode == lppd_pkg::MODE_LINE);
               lane_ctrl.cap_thr = (req_mode == lppd_pkg::MODE_BACKGROUND);
               lane_ctrl.cmp     = 1'b1;
               state_in = (req_mode == lppd_pkg::MODE_RUN) ? lppd_pkg::ST_SUM
                                                           : lppd_pkg::ST_DONE;
            end
         end
         lppd_pkg::ST_SUM: begin
            ctrl.sum_load = 1'b1;
            state_in      = lppd_pkg::ST_DIV;
         end
         lppd_pkg::ST_DIV: begin
            ctrl.div_load = 1'b1;
            state_in      = lppd_pkg::ST_POS;
         end
         lppd_pkg::ST_POS: begin
            ctrl.pos_load = 1'b1;
            state_in      = drive_en_ff ? lppd_pkg::ST_P : lppd_pkg::ST_DONE;
         end
         lppd_pkg::ST_P: begin
            ctrl.p_load = 1'b1;
            state_in    = lppd_pkg::ST_D;
         end
         lppd_pkg::ST_D: begin
            ctrl.d_load = 1'b1;
            state_in    = lppd_pkg::ST_I;
         end
         lppd_pkg::ST_I: begin
            ctrl.i_load = 1'b1;
            state_in    = lppd_pkg::ST_DONE;
         end
         lppd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = lppd_pkg::ST_IDLE;
            end
         end
         default: state_in = lppd_pkg::ST_IDLE;
      endcase
   end

   // ---------------- lanes, merge and PID ----------------
   for (genvar g = 0; g < NS; g++) begin : g_lane
      lppd_lane #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .sample (sample_vec[g]),
         .hit    (hits[g])
      );
   end

   lppd_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .hits     (hits),
      .position (position)
   );

   lppd_pid #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_pid (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .position   (position),
      .target     (target_ff),
      .gain_p     (gain_p_ff),
      .gain_d     (gain_d_ff),
      .gain_i     (gain_i_ff),
      .base_speed (base_ff),
      .drive      (drive)
   );

   // ---------------- result register ----------------
   assign run_item     = (mode_ff == lppd_pkg::MODE_RUN);
   assign rsp_drive_in = (run_item && drive_en_ff) ? drive : '0;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      if (rsp_load) begin
         rsp_position_ff  <= position;
         rsp_line_seen_ff <= run_item && (hits != '0);
         rsp_bits_ff      <= run_item ? hits : '0;
         rsp_drive_ff     <= rsp_drive_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_line_seen     = rsp_line_seen_ff;
   assign rsp_sensor_bits   = rsp_bits_ff;
   assign rsp_left_duty     = rsp_drive_ff.left_duty;
   assign rsp_left_reverse  = rsp_drive_ff.left_reverse;
   assign rsp_right_duty    = rsp_drive_ff.right_duty;
   assign rsp_right_reverse = rsp_drive_ff.right_reverse;

   // ---------------- assertions ----------------
   `LPPD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "word accepted while previous word still in work")
   `LPPD_ASSERT_SAME(a_seen_matches_bits, clock, reset, rsp_valid, rsp_line_seen == (rsp_sensor_bits != '0), "line seen flag disagrees with sensor bits")
   `LPPD_ASSERT_SAME(a_position_range, clock, reset, rsp_valid, rsp_position <= lppd_pkg::POS_MAX, "position beyond outer sensor")
   `LPPD_ASSERT_SAME(a_duty_limit, clock, reset, rsp_valid, (rsp_left_duty <= lppd_pkg::MAX_DUTY) && (rsp_right_duty <= lppd_pkg::MAX_DUTY), "duty above saturation limit")

endmodule

@@ rtl/lppd_lane.sv @@
// One sensor lane: line reference, threshold and the threshold compare.
module lppd_lane #(
   parameter int SAMPLE_BITS = lppd_pkg::SAMPLE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lppd_pkg::lane_ctrl_type ctrl,
   input  logic [SAMPLE_BITS-1:0]  sample,
   output logic                    hit
);

   logic [SAMPLE_BITS-1:0] line_ref_ff, line_ref_in;
   logic [SAMPLE_BITS-1:0] thr_ff, thr_in;
   logic                   hit_ff, hit_in;
   logic [SAMPLE_BITS:0]   mid_sum;

   always_comb begin
      mid_sum     = {1'b0, line_ref_ff} + {1'b0, sample};
      line_ref_in = ctrl.cap_ref ? sample : line_ref_ff;
      // The threshold sits halfway between line and background, rounded down.
      thr_in      = ctrl.cap_thr ? mid_sum[SAMPLE_BITS:1] : thr_ff;
      hit_in      = ctrl.cmp ? (sample >= thr_ff) : hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ref_ff <= '0;
         thr_ff      <= '0;
      end else begin
         line_ref_ff <= line_ref_in;
         thr_ff      <= thr_in;
      end
      hit_ff <= hit_in;
   end

   assign hit = hit_ff;

endmodule

@@ rtl/lppd_merge.sv @@
// Merging stage: hit count, weighted sum, centroid division and edge handling.
module lppd_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lppd_pkg::ctrl_type                   ctrl,
   input  logic [lppd_pkg::NUM_SENSORS-1:0]     hits,
   output logic [lppd_pkg::POS_W-1:0]           position
);

   localparam int PROD_W  = lppd_pkg::WSUM_W + lppd_pkg::RECIP_W;
   localparam int CHECK_W = lppd_pkg::WSUM_W + lppd_pkg::COUNT_W;

   logic [lppd_pkg::COUNT_W-1:0] count_ff, count_in, count_sum;
   logic [lppd_pkg::WSUM_W-1:0]  wsum_ff, wsum_in, weight_sum;
   logic [PROD_W-1:0]            prod_ff, prod_in;
   logic [lppd_pkg::POS_W-1:0]   pos_ff, pos_in, pos_new;
   logic [lppd_pkg::WSUM_W-1:0]  quot, quot_fix;
   logic [CHECK_W-1:0]           quot_check;

   always_comb begin
      count_sum  = '0;
      weight_sum = '0;
      for (int i = 0; i < lppd_pkg::NUM_SENSORS; i++) begin
         if (hits[i]) begin
            count_sum  = count_sum + 1'b1;
            weight_sum = weight_sum + lppd_pkg::WSUM_W'(lppd_pkg::PITCH * i);
         end
      end
      count_in = ctrl.sum_load ? count_sum : count_ff;
      wsum_in  = ctrl.sum_load ? weight_sum : wsum_ff;
   end

   always_comb begin
      prod_in = ctrl.div_load ? wsum_ff * lppd_pkg::RECIP_TABLE[count_ff] : prod_ff;
   end

   // The rounded-up reciprocal may overshoot by one; one check takes it back.
   always_comb begin
      quot       = prod_ff[lppd_pkg::RECIP_SHIFT +: lppd_pkg::WSUM_W];
      quot_check = quot * count_ff;
      quot_fix   = (quot_check > CHECK_W'(wsum_ff)) ? quot - 1'b1 : quot;

      if (count_ff != '0) begin
         pos_new = quot_fix[lppd_pkg::POS_W-1:0];
      end else if (pos_ff <= lppd_pkg::POS_W'(lppd_pkg::EDGE_MARGIN)) begin
         pos_new = '0;
      end else if (pos_ff >= lppd_pkg::POS_W'(lppd_pkg::POS_MAX - lppd_pkg::EDGE_MARGIN)) begin
         pos_new = lppd_pkg::POS_W'(lppd_pkg::POS_MAX);
      end else begin
         pos_new = pos_ff;
      end
      pos_in = ctrl.pos_load ? pos_new : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
      count_ff <= count_in;
      wsum_ff  <= wsum_in;
      prod_ff  <= prod_in;
   end

   assign position = pos_ff;

endmodule

@@ rtl/lppd_pid.sv @@
// PID step on one shared multiplier, error history and motor command shaping.
module lppd_pid #(
   parameter int HISTORY_DEPTH = lppd_pkg::HISTORY_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lppd_pkg::ctrl_type                  ctrl,
   input  logic [lppd_pkg::POS_W-1:0]          position,
   input  logic [lppd_pkg::TARGET_W-1:0]       target,
   input  logic [lppd_pkg::GAIN_W-1:0]         gain_p,
   input  logic [lppd_pkg::GAIN_W-1:0]         gain_d,
   input  logic [lppd_pkg::GAIN_W-1:0]         gain_i,
   input  logic signed [lppd_pkg::BASE_W-1:0]  base_speed,
   output lppd_pkg::drive_type                 drive
);

   localparam int ERR_W  = lppd_pkg::ERR_W;
   localparam int HSUM_W = ERR_W + $clog2(HISTORY_DEPTH);
   localparam int OPB_W  = (HSUM_W > lppd_pkg::DIFF_W) ? HSUM_W : lppd_pkg::DIFF_W;
   localparam int PROD_W = OPB_W + lppd_pkg::GAIN_W + 1;
   localparam int ACC_W  = PROD_W + 2;
   localparam int CMD_W  = ACC_W + 1;

   logic signed [ERR_W-1:0]            err_now;
   logic signed [ERR_W-1:0]            err_ff, err_in;
   logic signed [ERR_W-1:0]            prev_err_ff, prev_err_in;
   logic signed [ERR_W-1:0]            hist_ff [HISTORY_DEPTH];
   logic signed [ERR_W-1:0]            hist_in [HISTORY_DEPTH];
   logic signed [HSUM_W-1:0]           hsum_ff, hsum_in;
   logic signed [lppd_pkg::DIFF_W-1:0] diff;
   logic [lppd_pkg::GAIN_W-1:0]        gain_sel;
   logic signed [OPB_W-1:0]            opb;
   logic signed [PROD_W-1:0]           prod;
   logic signed [ACC_W-1:0]            acc_ff, acc_in;
   logic signed [CMD_W-1:0]            cmd_left, cmd_right;
   logic [lppd_pkg::DUTY_W:0]          out_left, out_right;

   // Returns the reverse flag above the saturated magnitude.
   function automatic logic [lppd_pkg::DUTY_W:0] shape(input logic signed [CMD_W-1:0] cmd);
      logic [CMD_W-1:0]          mag;
      logic [lppd_pkg::DUTY_W-1:0] duty;
      mag = cmd[CMD_W-1] ? $unsigned(-cmd) : $unsigned(cmd);
      if (mag > CMD_W'(lppd_pkg::MAX_DUTY)) begin
         duty = lppd_pkg::DUTY_W'(lppd_pkg::MAX_DUTY);
      end else begin
         duty = mag[lppd_pkg::DUTY_W-1:0];
      end
      return {cmd[CMD_W-1], duty};
   endfunction

   always_comb begin
      err_now = $signed({1'b0, position}) - $signed({1'b0, target});
      diff    = $signed({err_ff[ERR_W-1], err_ff}) - $signed({prev_err_ff[ERR_W-1], prev_err_ff});

      // One multiplier serves the three terms in turn.
      gain_sel = gain_p;
      opb      = OPB_W'(err_now);
      if (ctrl.d_load) begin
         gain_sel = gain_d;
         opb      = OPB_W'(diff);
      end else if (ctrl.i_load) begin
         gain_sel = gain_i;
         opb      = OPB_W'(hsum_ff);
      end
      prod = $signed({1'b0, gain_sel}) * opb;

      if (ctrl.p_load) begin
         acc_in = ACC_W'(prod);
      end else if (ctrl.d_load || ctrl.i_load) begin
         acc_in = acc_ff + ACC_W'(prod);
      end else begin
         acc_in = acc_ff;
      end
      err_in = ctrl.p_load ? err_now : err_ff;
   end

   // The history moves on only after its old sum has fed the integral term.
   always_comb begin
      hist_in     = hist_ff;
      hsum_in     = hsum_ff;
      prev_err_in = prev_err_ff;
      if (ctrl.i_load) begin
         hist_in[0] = err_ff;
         for (int k = 1; k < HISTORY_DEPTH; k++) begin
            hist_in[k] = hist_ff[k-1];
         end
         hsum_in     = hsum_ff + HSUM_W'(err_ff) - HSUM_W'(hist_ff[HISTORY_DEPTH-1]);
         prev_err_in = err_ff;
      end
   end

   always_comb begin
      cmd_left  = CMD_W'(base_speed) + CMD_W'(acc_ff);
      cmd_right = CMD_W'(base_speed) - CMD_W'(acc_ff);
      out_left  = shape(cmd_left);
      out_right = shape(cmd_right);
      drive.left_reverse  = out_left[lppd_pkg::DUTY_W];
      drive.left_duty     = out_left[lppd_pkg::DUTY_W-1:0];
      drive.right_reverse = out_right[lppd_pkg::DUTY_W];
      drive.right_duty    = out_right[lppd_pkg::DUTY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
         hsum_ff     <= '0;
         prev_err_ff <= '0;
      end else begin
         hist_ff     <= hist_in;
         hsum_ff     <= hsum_in;
         prev_err_ff <= prev_err_in;
      end
      err_ff <= err_in;
      acc_ff <= acc_in;
   end

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the line position sensor and PID drive block.
`timescale 1ns / 1ps

module tb_top;
   import lppd_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 400;
   localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]                        mode;
      logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0]  samples;
   } sensor_frame_t;

   typedef struct packed {
      logic [POS_W-1:0]       position;
      logic                   line_seen;
      logic [NUM_SENSORS-1:0] sensor_bits;
      logic [DUTY_W-1:0]      left_duty;
      logic                   left_reverse;
      logic [DUTY_W-1:0]      right_duty;
      logic                   right_reverse;
   } drive_result_t;

   typedef struct packed {
      logic          fixed;
      drive_result_t res;
   } frame_note_t;

   typedef struct packed {
      sensor_frame_t frame;
      frame_note_t   note;
   } directed_row_t;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [MODE_W-1:0] req_mode;
   logic [SAMPLE_BITS-1:0] req_sample_0, req_sample_1, req_sample_2, req_sample_3;
   logic [SAMPLE_BITS-1:0] req_sample_4, req_sample_5, req_sample_6, req_sample_7;
   logic rsp_valid;
   logic rsp_ready;
   logic [POS_W-1:0] rsp_position;
   logic rsp_line_seen;
   logic [NUM_SENSORS-1:0] rsp_sensor_bits;
   logic [DUTY_W-1:0] rsp_left_duty;
   logic rsp_left_reverse;
   logic [DUTY_W-1:0] rsp_right_duty;
   logic rsp_right_reverse;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   line_position_pid_drive_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_sample_0      (req_sample_0),
      .req_sample_1      (req_sample_1),
      .req_sample_2      (req_sample_2),
      .req_sample_3      (req_sample_3),
      .req_sample_4      (req_sample_4),
      .req_sample_5      (req_sample_5),
      .req_sample_6      (req_sample_6),
      .req_sample_7      (req_sample_7),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_position      (rsp_position),
      .rsp_line_seen     (rsp_line_seen),
      .rsp_sensor_bits   (rsp_sensor_bits),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_left_reverse  (rsp_left_reverse),
      .rsp_right_duty    (rsp_right_duty),
      .rsp_right_reverse (rsp_right_reverse),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // Shadow of the block's state and registers.
   logic [SAMPLE_BITS-1:0] ref_level [NUM_SENSORS];
   logic [SAMPLE_BITS-1:0] thr_level [NUM_SENSORS];
   logic [POS_W-1:0]       last_pos;
   int                     last_err;
   int                     err_hist [HISTORY_DEPTH];
   logic [TARGET_W-1:0]    cfg_target;
   int                     cfg_gain_p;
   int                     cfg_gain_d;
   int                     cfg_gain_i;
   int                     cfg_base;
   logic                   cfg_drive;

   drive_result_t   pending_results [$];
   frame_note_t     frame_notes [$];
   directed_row_t   directed_rows [$];
   int              mismatch_count;
   int              cycle_count;
   bit              idle_on;
   bit              long_hold;
   int              rx_hold;
   int              rx_gap;

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   function automatic logic [DUTY_W:0] motor_word(input longint cmd);
      longint mag;
      logic   rev;
      rev = cmd < 0;
      mag = rev ? -cmd : cmd;
      if (mag > MAX_DUTY) mag = MAX_DUTY;
      return {DUTY_W'(mag), rev};
   endfunction

   function automatic drive_result_t predict_drive(input sensor_frame_t f);
      drive_result_t r;
      int            hits;
      int            wsum;
      int            err;
      logic [POS_W-1:0] pos;
      longint        hsum;
      longint        pid;
      r = '0;
      if (f.mode == MODE_LINE) begin
         for (int i = 0; i < NUM_SENSORS; i++) ref_level[i] = f.samples[i];
      end else if (f.mode == MODE_BACKGROUND) begin
         for (int i = 0; i < NUM_SENSORS; i++)
            thr_level[i] = SAMPLE_BITS'(({1'b0, ref_level[i]} + {1'b0, f.samples[i]}) >> 1);
      end
      if (f.mode != MODE_RUN) begin
         r.position = last_pos;
         return r;
      end
      hits = 0;
      wsum = 0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         if (f.samples[i] >= thr_level[i]) begin
            r.sensor_bits[i] = 1'b1;
            hits++;
            wsum += PITCH * i;
         end
      end
      // With no line in view the position snaps to an edge it was already close to.
      if (hits != 0) pos = POS_W'(wsum / hits);
      else if (last_pos <= EDGE_MARGIN) pos = '0;
      else if (last_pos >= POS_MAX - EDGE_MARGIN) pos = POS_W'(POS_MAX);
      else pos = last_pos;
      last_pos = pos;
      r.position = pos;
      r.line_seen = hits != 0;
      if (cfg_drive) begin
         err = int'(pos) - int'(cfg_target);
         hsum = 0;
         for (int i = 0; i < HISTORY_DEPTH; i++) hsum += err_hist[i];
         pid = longint'(cfg_gain_p) * err + longint'(cfg_gain_d) * (err - last_err)
             + longint'(cfg_gain_i) * hsum;
         for (int i = HISTORY_DEPTH - 1; i > 0; i--) err_hist[i] = err_hist[i - 1];
         err_hist[0] = err;
         last_err = err;
         {r.left_duty, r.left_reverse}   = motor_word(cfg_base + pid);
         {r.right_duty, r.right_reverse} = motor_word(cfg_base - pid);
      end
      return r;
   endfunction

   function automatic directed_row_t dir_row(input logic [MODE_W-1:0] mode,
                                             input logic [NUM_SENSORS-1:0] mask,
                                             input int hi, input int lo, input logic fixed,
                                             input int pos, input logic seen,
                                             input logic [NUM_SENSORS-1:0] bits);
      directed_row_t row;
      row = '0;
      row.frame.mode = mode;
      for (int i = 0; i < NUM_SENSORS; i++)
         row.frame.samples[i] = SAMPLE_BITS'(mask[i] ? hi : lo);
      row.note.fixed = fixed;
      row.note.res.position = POS_W'(pos);
      row.note.res.line_seen = seen;
      row.note.res.sensor_bits = bits;
      return row;
   endfunction

   function automatic sensor_frame_t rand_frame(input logic [MODE_W-1:0] mode,
                                                input int lo, input int hi);
      sensor_frame_t f;
      f.mode = mode;
      for (int i = 0; i < NUM_SENSORS; i++)
         f.samples[i] = SAMPLE_BITS'($urandom_range(lo, hi));
      return f;
   endfunction

   // A run word aimed at the current thresholds: a short window of sensors on
   // the line, the rest below the thresholds, with a stray hit now and then.
   function automatic sensor_frame_t run_frame();
      sensor_frame_t f;
      int start;
      int width;
      int thr;
      int v;
      if ($urandom_range(0, 9) == 0) return rand_frame(MODE_RUN, 0, SAMPLE_MAX);
      f.mode = MODE_RUN;
      start = $urandom_range(0, NUM_SENSORS - 1);
      width = $urandom_range(0, 3);
      for (int i = 0; i < NUM_SENSORS; i++) begin
         thr = int'(thr_level[i]);
         if ((i >= start && i < start + width) || $urandom_range(0, 15) == 0)
            v = ($urandom_range(0, 1) != 0) ? thr + $urandom_range(0, 2)
                                            : $urandom_range(thr, SAMPLE_MAX);
         else if (thr == 0)
            v = 0;
         else
            v = ($urandom_range(0, 1) != 0) ? thr - 1 : $urandom_range(0, thr - 1);
         if (v > SAMPLE_MAX) v = SAMPLE_MAX;
         f.samples[i] = SAMPLE_BITS'(v);
      end
      return f;
   endfunction

   task automatic send_word(input sensor_frame_t f, input frame_note_t note);
      int gap;
      frame_notes.push_back(note);
      req_valid    <= 1'b1;
      req_mode     <= f.mode;
      req_sample_0 <= f.samples[0];
      req_sample_1 <= f.samples[1];
      req_sample_2 <= f.samples[2];
      req_sample_3 <= f.samples[3];
      req_sample_4 <= f.samples[4];
      req_sample_5 <= f.samples[5];
      req_sample_6 <= f.samples[6];
      req_sample_7 <= f.samples[7];
      do @(posedge clock); while (!req_ready);
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0 || frame_notes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_TARGET: cfg_target = value[TARGET_W-1:0];
         REG_GAIN_P: cfg_gain_p = int'(value[GAIN_W-1:0]);
         REG_GAIN_D: cfg_gain_d = int'(value[GAIN_W-1:0]);
         REG_GAIN_I: cfg_gain_i = int'(value[GAIN_W-1:0]);
         REG_BASE:   cfg_base   = int'($signed(value[BASE_W-1:0]));
         REG_DRIVE:  cfg_drive  = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int target, input int gp, input int gd, input int gi,
                             input int base, input int drive);
      write_reg(REG_TARGET, CSR_DATA_W'(target));
      write_reg(REG_GAIN_P, CSR_DATA_W'(gp));
      write_reg(REG_GAIN_D, CSR_DATA_W'(gd));
      write_reg(REG_GAIN_I, CSR_DATA_W'(gi));
      write_reg(REG_BASE, {{(CSR_DATA_W - BASE_W){1'b0}}, BASE_W'(base)});
      write_reg(REG_DRIVE, CSR_DATA_W'(drive));
   endtask

   // Each phase calibrates first, then mostly runs, with some noise and
   // out-of-order capture words mixed in.
   task automatic run_phase(input int count, input bit hold);
      frame_note_t plain;
      int pick;
      plain = '0;
      send_word(rand_frame(MODE_LINE, 2500, SAMPLE_MAX), plain);
      send_word(rand_frame(MODE_BACKGROUND, 0, 1500), plain);
      for (int n = 0; n < count; n++) begin
         if (hold && n == count / 3) long_hold = 1'b1;
         pick = $urandom_range(0, 19);
         if (pick <= 16)
            send_word(run_frame(), plain);
         else if (pick == 17)
            send_word(rand_frame(MODE_W'($urandom_range(0, 3)), 0, SAMPLE_MAX), plain);
         else if (pick == 18)
            send_word(rand_frame(MODE_LINE, 0, SAMPLE_MAX), plain);
         else
            send_word(rand_frame(MODE_BACKGROUND, 0, SAMPLE_MAX), plain);
      end
      drain();
   endtask

   function automatic int rand_base();
      return int'($urandom_range(0, 200)) - 100;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("line_position_pid_drive_core: mismatch");
         $finish;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      rx_hold = 0;
      rx_gap = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rx_hold = HOLD_CYCLES;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(1, 9) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      sensor_frame_t frame;
      drive_result_t want;
      frame_note_t   note;
      if (!reset) begin
         if (req_valid && req_ready) begin
            frame.mode = req_mode;
            frame.samples = {req_sample_7, req_sample_6, req_sample_5, req_sample_4,
                             req_sample_3, req_sample_2, req_sample_1, req_sample_0};
            want = predict_drive(frame);
            note = '0;
            if (frame_notes.size() != 0) note = frame_notes.pop_front();
            if (note.fixed) want = note.res;
            pending_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result word with no expectation waiting");
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (want.position !== rsp_position) begin
                  $error("position: expected %0d, actual %0d", want.position, rsp_position);
                  mismatch_count++;
               end
               if (want.line_seen !== rsp_line_seen) begin
                  $error("line_seen: expected %0d, actual %0d", want.line_seen, rsp_line_seen);
                  mismatch_count++;
               end
               if (want.sensor_bits !== rsp_sensor_bits) begin
                  $error("sensor_bits: expected %h, actual %h", want.sensor_bits,
                         rsp_sensor_bits);
                  mismatch_count++;
               end
               if (want.left_duty !== rsp_left_duty) begin
                  $error("left_duty: expected %0d, actual %0d", want.left_duty, rsp_left_duty);
                  mismatch_count++;
               end
               if (want.left_reverse !== rsp_left_reverse) begin
                  $error("left_reverse: expected %0d, actual %0d", want.left_reverse,
                         rsp_left_reverse);
                  mismatch_count++;
               end
               if (want.right_duty !== rsp_right_duty) begin
                  $error("right_duty: expected %0d, actual %0d", want.right_duty,
                         rsp_right_duty);
                  mismatch_count++;
               end
               if (want.right_reverse !== rsp_right_reverse) begin
                  $error("right_reverse: expected %0d, actual %0d", want.right_reverse,
                         rsp_right_reverse);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_LINE;
      {req_sample_0, req_sample_1, req_sample_2, req_sample_3} = '0;
      {req_sample_4, req_sample_5, req_sample_6, req_sample_7} = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatch_count = 0;
      cycle_count = 0;
      idle_on = 1'b1;
      long_hold = 1'b0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         ref_level[i] = '0;
         thr_level[i] = '0;
      end
      for (int i = 0; i < HISTORY_DEPTH; i++) err_hist[i] = 0;
      last_pos = '0;
      last_err = 0;
      cfg_target = TARGET_RESET;
      cfg_gain_p = 0;
      cfg_gain_d = 0;
      cfg_gain_i = 0;
      cfg_base = int'($signed(BASE_RESET));
      cfg_drive = 1'b0;

      // Thresholds start at zero, so every sensor sees the line until calibrated.
      directed_rows.push_back(dir_row(MODE_SPARE, 8'h00, 0, SAMPLE_MAX, 1, 0, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h00, 0, 0, 1, 350, 1, 8'hFF));
      directed_rows.push_back(dir_row(MODE_LINE, 8'hFF, SAMPLE_MAX, 0, 1, 350, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_BACKGROUND, 8'h00, 0, 0, 1, 350, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h00, 0, 0, 1, 350, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h01, SAMPLE_MAX, 0, 1, 0, 1, 8'h01));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h00, 0, 0, 1, 0, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h80, SAMPLE_MAX, 0, 1, 700, 1, 8'h80));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h00, 0, 0, 1, 700, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h18, SAMPLE_MAX, 0, 1, 350, 1, 8'h18));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h07, SAMPLE_MAX, 0, 1, 100, 1, 8'h07));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h00, 0, 0, 1, 100, 0, 8'h00));
      // Threshold is 2047 here: equal counts as seen, one below does not.
      directed_rows.push_back(dir_row(MODE_RUN, 8'h20, 2047, 2046, 1, 500, 1, 8'h20));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h03, SAMPLE_MAX, 0, 1, 50, 1, 8'h03));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h00, 0, 0, 1, 0, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_RUN, 8'hC0, SAMPLE_MAX, 0, 1, 650, 1, 8'hC0));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h00, 0, 0, 1, 700, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_RUN, 8'hE0, SAMPLE_MAX, 0, 1, 600, 1, 8'hE0));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h00, 0, 0, 1, 600, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_SPARE, 8'hFF, SAMPLE_MAX, 0, 1, 600, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_RUN, 8'hFF, SAMPLE_MAX, 0, 1, 350, 1, 8'hFF));
      directed_rows.push_back(dir_row(MODE_LINE, 8'h55, SAMPLE_MAX, 0, 0, 0, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_BACKGROUND, 8'hAA, SAMPLE_MAX, 0, 0, 0, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h5A, 3000, 1000, 0, 0, 0, 8'h00));
      directed_rows.push_back(dir_row(MODE_RUN, 8'h0B, 3000, 1000, 0, 0, 0, 8'h00));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) send_word(directed_rows[k].frame, directed_rows[k].note);
      drain();

      set_config(350, 1, 0, 0, 20, 1);
      run_phase(150, 1'b0);
      set_config(700, 255, 255, 255, 100, 1);
      run_phase(110, 1'b1);
      set_config(0, 0, 0, 0, -100, 1);
      run_phase(60, 1'b0);
      // Zero gains and zero base give a zero command on both motors.
      set_config(350, 0, 0, 0, 0, 1);
      run_phase(40, 1'b0);
      set_config(1023, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), rand_base(), 1);
      run_phase(110, 1'b0);
      set_config($urandom_range(0, 700), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), rand_base(), 0);
      run_phase(100, 1'b0);
      set_config($urandom_range(0, 700), $urandom_range(0, 3), $urandom_range(0, 3),
                 $urandom_range(0, 1), rand_base(), 1);
      run_phase(150, 1'b0);
      idle_on = 1'b0;
      set_config($urandom_range(0, 700), $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 3), rand_base(), 1);
      run_phase(200, 1'b0);

      if (mismatch_count == 0) begin
         $display("line_position_pid_drive_core: match");
      end else begin
         $display("line_position_pid_drive_core: mismatch");
      end
      $finish;
   end

endmodule
